@@ rtl/core/weighted_random_child_select_assert.svh @@
// Assertion macros for the weighted random child select block.
// Used by weighted_random_child_select.sv; no other dependencies.
`ifndef WEIGHTED_RANDOM_CHILD_SELECT_ASSERT_SVH
`define WEIGHTED_RANDOM_CHILD_SELECT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define WRCS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define WRCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/wrcs_pkg.sv @@
// Package for the weighted random child select block: widths, constants
// and configuration register indexes. No dependencies.
package wrcs_pkg;

    localparam int MAX_CHILDREN = 8;
    localparam int CHILD_W      = 3;   // child index width
    localparam int CNT_W        = 4;   // child/weight count width
    localparam int WGT_W        = 7;   // clamped weight, 0..127
    localparam int SUM_W        = 10;  // sum of up to 8 weights
    localparam int RND_W        = 16;
    localparam int PROD_W       = RND_W + SUM_W;
    localparam int TABLE_W      = 64;
    localparam int CFG_IDX_W    = 2;

    // Weight of a child without explicit entry: 1.0 in Q3.4
    localparam logic [WGT_W-1:0] WEIGHT_ONE = 7'd16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHILD_COUNT  = 2'd0,
        CFG_WEIGHT_COUNT = 2'd1,
        CFG_WEIGHT_TABLE = 2'd2
    } t_cfg_idx;

endpackage

@@ rtl/core/weighted_random_child_select.sv @@
// Weighted random child select: four-stage roulette wheel pipeline.
// Depends on wrcs_pkg and weighted_random_child_select_assert.svh.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------------
//  request  | start, busy               | i_first_visit, i_allowed_mask, i_random_word
//  result   | o_strobe                  | o_go_to_parent, o_chosen_child
//  config   | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
// One transaction per cycle while busy is low; each result passes the stage 1, 2, 3 and output registers.
// Stages: weight clamp and masking, prefix sums, multiplies, compare and pick.
// busy is high only while reset is held; reset clears all stage valid bits and
// the configuration registers. The receiver cannot stall: o_strobe lasts one
// cycle and the pipeline never holds.
module weighted_random_child_select (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_first_visit,
    input  logic [wrcs_pkg::MAX_CHILDREN-1:0]    i_allowed_mask,
    input  logic [wrcs_pkg::RND_W-1:0]           i_random_word,
    output logic                                 o_strobe,
    output logic                                 o_go_to_parent,
    output logic [wrcs_pkg::CHILD_W-1:0]         o_chosen_child,
    input  logic                                 i_cfg_we,
    input  logic [wrcs_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [wrcs_pkg::TABLE_W-1:0]         i_cfg_data
);

    localparam int N = wrcs_pkg::MAX_CHILDREN;

    // Configuration registers
    logic [wrcs_pkg::CNT_W-1:0]   r_child_count;
    logic [wrcs_pkg::CNT_W-1:0]   r_weight_count;
    logic [wrcs_pkg::TABLE_W-1:0] r_weight_table;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_child_count  <= '0;
            r_weight_count <= '0;
            r_weight_table <= '0;
        end else if (i_cfg_we) begin
            case (wrcs_pkg::t_cfg_idx'(i_cfg_idx))
                wrcs_pkg::CFG_CHILD_COUNT:  r_child_count  <= i_cfg_data[wrcs_pkg::CNT_W-1:0];
                wrcs_pkg::CFG_WEIGHT_COUNT: r_weight_count <= i_cfg_data[wrcs_pkg::CNT_W-1:0];
                wrcs_pkg::CFG_WEIGHT_TABLE: r_weight_table <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = !i_rst_n;

    logic accept;
    assign accept = start && !busy;

    // ---------------- Stage 1: clamp weights, mask absent children
    logic [wrcs_pkg::CNT_W-1:0] cnt_eff;
    logic [N-1:0]               n_s1_m;
    logic [wrcs_pkg::WGT_W-1:0] n_s1_w [N];
    logic                       n_s1_parent;
    logic [7:0]                 raw_byte;

    always_comb begin
        raw_byte = '0;
        cnt_eff  = (r_child_count > wrcs_pkg::CNT_W'(N)) ? wrcs_pkg::CNT_W'(N) : r_child_count;
        for (int i = 0; i < N; i++) begin
            n_s1_m[i] = i_allowed_mask[i] && (wrcs_pkg::CNT_W'(i) < cnt_eff);
            raw_byte  = r_weight_table[8*i +: 8];
            if (wrcs_pkg::CNT_W'(i) >= r_weight_count) begin
                n_s1_w[i] = wrcs_pkg::WEIGHT_ONE;
            end else if (raw_byte[7]) begin
                n_s1_w[i] = '0;   // negative weight counts as zero
            end else begin
                n_s1_w[i] = raw_byte[wrcs_pkg::WGT_W-1:0];
            end
            if (!n_s1_m[i]) begin
                n_s1_w[i] = '0;
            end
        end
        n_s1_parent = (cnt_eff == '0) || !i_first_visit || (n_s1_m == '0);
    end

    logic                       r_s1_valid;
    logic                       r_s1_parent;
    logic [N-1:0]               r_s1_m;
    logic [wrcs_pkg::WGT_W-1:0] r_s1_w [N];
    logic [wrcs_pkg::RND_W-1:0] r_s1_rnd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_parent <= n_s1_parent;
        r_s1_m      <= n_s1_m;
        r_s1_w      <= n_s1_w;
        r_s1_rnd    <= i_random_word;
    end

    // ---------------- Stage 2: running sums and allowed count
    logic [wrcs_pkg::SUM_W-1:0] n_s2_sum [N];
    logic [wrcs_pkg::SUM_W-1:0] acc;

    always_comb begin
        acc = '0;
        for (int i = 0; i < N; i++) begin
            acc         = acc + wrcs_pkg::SUM_W'(r_s1_w[i]);
            n_s2_sum[i] = acc;
        end
    end

    logic                       r_s2_valid;
    logic                       r_s2_parent;
    logic [N-1:0]               r_s2_m;
    logic [wrcs_pkg::SUM_W-1:0] r_s2_sum [N];
    logic [wrcs_pkg::CNT_W-1:0] r_s2_n;
    logic [wrcs_pkg::RND_W-1:0] r_s2_rnd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_parent <= r_s1_parent;
        r_s2_m      <= r_s1_m;
        r_s2_sum    <= n_s2_sum;
        r_s2_n      <= wrcs_pkg::CNT_W'($countones(r_s1_m));
        r_s2_rnd    <= r_s1_rnd;
    end

    // ---------------- Stage 3: random * total, zero-total slot index
    logic [wrcs_pkg::PROD_W-1:0]        n_s3_prod;
    logic [wrcs_pkg::RND_W+wrcs_pkg::CNT_W-1:0] kprod;
    logic [wrcs_pkg::CNT_W-1:0]         n_s3_k;

    always_comb begin
        n_s3_prod = wrcs_pkg::PROD_W'(r_s2_rnd) * wrcs_pkg::PROD_W'(r_s2_sum[N-1]);
        kprod     = (wrcs_pkg::RND_W+wrcs_pkg::CNT_W)'(r_s2_rnd)
                  * (wrcs_pkg::RND_W+wrcs_pkg::CNT_W)'(r_s2_n);
        n_s3_k    = kprod[wrcs_pkg::RND_W +: wrcs_pkg::CNT_W];
        if (n_s3_k >= r_s2_n && r_s2_n != '0) begin
            n_s3_k = r_s2_n - 1'b1;
        end
    end

    logic                        r_s3_valid;
    logic                        r_s3_parent;
    logic                        r_s3_zero;
    logic [N-1:0]                r_s3_m;
    logic [wrcs_pkg::SUM_W-1:0]  r_s3_sum [N];
    logic [wrcs_pkg::PROD_W-1:0] r_s3_prod;
    logic [wrcs_pkg::CNT_W-1:0]  r_s3_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_parent <= r_s2_parent;
        r_s3_zero   <= (r_s2_sum[N-1] == '0);
        r_s3_m      <= r_s2_m;
        r_s3_sum    <= r_s2_sum;
        r_s3_prod   <= n_s3_prod;
        r_s3_k      <= n_s3_k;
    end

    // ---------------- Stage 4: wheel compare and pick
    logic [wrcs_pkg::CHILD_W-1:0] pick_wheel;
    logic [wrcs_pkg::CHILD_W-1:0] pick_zero;
    logic [wrcs_pkg::CHILD_W-1:0] pick_last;
    logic                         wheel_hit;
    logic [wrcs_pkg::CNT_W-1:0]   run;
    logic [wrcs_pkg::CHILD_W-1:0] n_child;

    always_comb begin
        pick_wheel = '0;
        pick_zero  = '0;
        pick_last  = '0;
        wheel_hit  = 1'b0;
        run        = '0;
        // last allowed child, used when the wheel falls through
        for (int i = 0; i < N; i++) begin
            if (r_s3_m[i]) begin
                pick_last = wrcs_pkg::CHILD_W'(i);
            end
        end
        // first allowed child whose running sum covers the draw
        for (int i = N-1; i >= 0; i--) begin
            if (r_s3_m[i] && ({r_s3_sum[i], 16'h0000} >= r_s3_prod)) begin
                pick_wheel = wrcs_pkg::CHILD_W'(i);
                wheel_hit  = 1'b1;
            end
        end
        // k-th allowed child when every weight is zero
        for (int i = 0; i < N; i++) begin
            if (r_s3_m[i]) begin
                if (run == r_s3_k) begin
                    pick_zero = wrcs_pkg::CHILD_W'(i);
                end
                run = run + 1'b1;
            end
        end
        if (r_s3_parent) begin
            n_child = '0;
        end else if (r_s3_zero) begin
            n_child = pick_zero;
        end else if (wheel_hit) begin
            n_child = pick_wheel;
        end else begin
            n_child = pick_last;
        end
    end

    logic                         r_out_valid;
    logic                         r_out_parent;
    logic [wrcs_pkg::CHILD_W-1:0] r_out_child;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_parent <= r_s3_parent;
        r_out_child  <= n_child;
    end

    assign o_strobe       = r_out_valid;
    assign o_go_to_parent = r_out_parent;
    assign o_chosen_child = r_out_child;

    // ---------------- Assertions
`include "weighted_random_child_select_assert.svh"

    `WRCS_ASSERT_NOW(a_parent_child_zero, i_clk, i_rst_n, o_strobe && o_go_to_parent, o_chosen_child == '0, "return-to-parent result carries a nonzero child")
    `WRCS_ASSERT_NEXT(a_pick_is_allowed, i_clk, i_rst_n, r_s3_valid && !r_s3_parent, r_out_child <= wrcs_pkg::CHILD_W'(N-1) && (($past(r_s3_m) >> o_chosen_child) & 8'h01) == 8'h01, "chosen child is not an allowed child")
    `WRCS_ASSERT_NEXT(a_pipe_latency, i_clk, i_rst_n, r_s1_valid, ##1 r_s3_valid ##1 o_strobe, "transaction lost in the pipeline")
    `WRCS_ASSERT_NOW(a_live_has_mask, i_clk, i_rst_n, r_s2_valid && !r_s2_parent, r_s2_m != '0 && r_s2_n != '0, "child pick with empty allowed set")

endmodule

@@ test/tb_weighted_random_child_select.sv @@
// Testbench for weighted_random_child_select: directed and random requests are checked
// against a roulette wheel predictor kept inside this file.
// Depends on wrcs_pkg and the RTL of weighted_random_child_select.
module tb_weighted_random_child_select;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 7;
    localparam int PIPE_LATENCY   = 4;
    localparam int STALL_LIMIT    = 2000;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_REQUESTS = 150;

    typedef struct {
        bit                              first;
        bit [wrcs_pkg::MAX_CHILDREN-1:0] mask;
        bit [wrcs_pkg::RND_W-1:0]        word;
    } t_request;

    typedef struct {
        bit                         go_to_parent;
        bit [wrcs_pkg::CHILD_W-1:0] child;
    } t_pick;

    // DUT connections
    logic                              i_clk          = 1'b0;
    logic                              i_rst_n        = 1'b0;
    logic                              start          = 1'b0;
    logic                              busy;
    logic                              i_first_visit  = 1'b0;
    logic [wrcs_pkg::MAX_CHILDREN-1:0] i_allowed_mask = '0;
    logic [wrcs_pkg::RND_W-1:0]        i_random_word  = '0;
    logic                              o_strobe;
    logic                              o_go_to_parent;
    logic [wrcs_pkg::CHILD_W-1:0]      o_chosen_child;
    logic                              i_cfg_we       = 1'b0;
    logic [wrcs_pkg::CFG_IDX_W-1:0]    i_cfg_idx      = wrcs_pkg::CFG_CHILD_COUNT;
    logic [wrcs_pkg::TABLE_W-1:0]      i_cfg_data     = '0;

    // Predictor copy of the configuration registers
    bit [wrcs_pkg::CNT_W-1:0]   model_child_count  = '0;
    bit [wrcs_pkg::CNT_W-1:0]   model_weight_count = '0;
    bit [wrcs_pkg::TABLE_W-1:0] model_weight_tbl   = '0;

    t_request    pending_requests[$];
    t_pick       expected_picks[$];
    int unsigned idle_pct         = 0;
    int unsigned mismatch_count   = 0;
    int unsigned requests_taken   = 0;
    int unsigned settings_applied = 0;
    int unsigned parent_results   = 0;
    int unsigned child_results    = 0;
    int unsigned stall_cycles     = 0;
    int unsigned idle_profile[3]  = '{0, 59, 26};

    weighted_random_child_select DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_first_visit  (i_first_visit),
        .i_allowed_mask (i_allowed_mask),
        .i_random_word  (i_random_word),
        .o_strobe       (o_strobe),
        .o_go_to_parent (o_go_to_parent),
        .o_chosen_child (o_chosen_child),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Clamped Q3.4 weight of one child; children without an entry weigh 1.0
    function automatic int unsigned child_weight(int unsigned idx);
        bit [7:0] raw;
        if (idx >= model_weight_count)
            return 32'(wrcs_pkg::WEIGHT_ONE);
        raw = model_weight_tbl[8*idx +: 8];
        return raw[7] ? 32'd0 : 32'(raw);
    endfunction

    function automatic int unsigned present_children();
        if (model_child_count > wrcs_pkg::CNT_W'(wrcs_pkg::MAX_CHILDREN))
            return unsigned'(wrcs_pkg::MAX_CHILDREN);
        return 32'(model_child_count);
    endfunction

    // Roulette wheel over the allowed children in ascending order
    function automatic t_pick predict_pick(t_request req);
        t_pick       res;
        int unsigned slots[wrcs_pkg::MAX_CHILDREN];
        int unsigned n_allowed;
        int unsigned total;
        int unsigned running;
        int unsigned k;
        res.go_to_parent = 1'b1;
        res.child        = '0;
        n_allowed        = 0;
        total            = 0;
        running          = 0;
        if (present_children() == 0 || !req.first)
            return res;
        for (int unsigned i = 0; i < present_children(); i++) begin
            if (req.mask[i]) begin
                slots[n_allowed] = i;
                n_allowed++;
                total += child_weight(i);
            end
        end
        if (n_allowed == 0)
            return res;
        res.go_to_parent = 1'b0;
        if (total == 0) begin
            // all weights clamped away: uniform pick among allowed children
            k = (32'(req.word) * n_allowed) >> 16;
            if (k >= n_allowed)
                k = n_allowed - 1;
            res.child = wrcs_pkg::CHILD_W'(slots[k]);
            return res;
        end
        res.child = wrcs_pkg::CHILD_W'(slots[n_allowed-1]);
        for (int unsigned i = 0; i < n_allowed; i++) begin
            running += child_weight(slots[i]);
            if (32'(req.word) * total <= (running << 16)) begin
                res.child = wrcs_pkg::CHILD_W'(slots[i]);
                break;
            end
        end
        return res;
    endfunction

    // Random word placed right at, or one past, a prefix boundary of the wheel
    function automatic bit [wrcs_pkg::RND_W-1:0] wheel_edge_word(
            bit [wrcs_pkg::MAX_CHILDREN-1:0] mask);
        int unsigned total;
        int unsigned running;
        int unsigned n_allowed;
        int unsigned target;
        int unsigned edge_word;
        total     = 0;
        n_allowed = 0;
        for (int unsigned i = 0; i < present_children(); i++) begin
            if (mask[i]) begin
                total += child_weight(i);
                n_allowed++;
            end
        end
        if (total == 0)
            return wrcs_pkg::RND_W'($urandom);
        target  = $urandom_range(n_allowed - 1);
        running = 0;
        for (int unsigned i = 0; i < present_children(); i++) begin
            if (mask[i]) begin
                running += child_weight(i);
                if (target == 0)
                    break;
                target--;
            end
        end
        edge_word = (running << 16) / total + $urandom_range(1);
        if (edge_word > 32'hFFFF)
            edge_word = 32'hFFFF;
        return edge_word[wrcs_pkg::RND_W-1:0];
    endfunction

    // Driver: hold the current transaction until taken, then load the next one
    always @(posedge i_clk) begin
        t_request req;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || busy === 1'b0) begin
            if (start) begin
                expected_picks.push_back(predict_pick('{i_first_visit, i_allowed_mask,
                                                        i_random_word}));
                requests_taken++;
            end
            if (pending_requests.size() > 0 && $urandom_range(99) >= idle_pct) begin
                req = pending_requests.pop_front();
                start          <= 1'b1;
                i_first_visit  <= req.first;
                i_allowed_mask <= req.mask;
                i_random_word  <= req.word;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: every strobe must match the oldest expected pick
    always @(posedge i_clk) begin
        t_pick exp_pick;
        if (i_rst_n && o_strobe === 1'b1) begin
            if (expected_picks.size() == 0) begin
                $display("%0t: unexpected result go_to_parent=%0b child=%0d", $time,
                         o_go_to_parent, o_chosen_child);
                mismatch_count++;
            end else begin
                exp_pick = expected_picks.pop_front();
                if (o_go_to_parent !== exp_pick.go_to_parent) begin
                    $display("%0t: go_to_parent expected %0b actual %0b", $time,
                             exp_pick.go_to_parent, o_go_to_parent);
                    mismatch_count++;
                end
                if (o_chosen_child !== exp_pick.child) begin
                    $display("%0t: chosen_child expected %0d actual %0d", $time,
                             exp_pick.child, o_chosen_child);
                    mismatch_count++;
                end
                if (exp_pick.go_to_parent)
                    parent_results++;
                else
                    child_results++;
            end
        end
    end

    // Watchdog on cycles where no transaction moves either way
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && busy === 1'b0) || o_strobe === 1'b1)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic queue_request(bit first, bit [wrcs_pkg::MAX_CHILDREN-1:0] mask,
                                 bit [wrcs_pkg::RND_W-1:0] word);
        pending_requests.push_back('{first, mask, word});
    endtask

    // Wait until every queued request has come back, then let the pipe empty
    task automatic wait_drained();
        while (pending_requests.size() != 0 || start || expected_picks.size() != 0)
            @(posedge i_clk);
        repeat (2 * PIPE_LATENCY) @(posedge i_clk);
    endtask

    task automatic write_reg(wrcs_pkg::t_cfg_idx idx, bit [wrcs_pkg::TABLE_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            wrcs_pkg::CFG_CHILD_COUNT:  model_child_count  = data[wrcs_pkg::CNT_W-1:0];
            wrcs_pkg::CFG_WEIGHT_COUNT: model_weight_count = data[wrcs_pkg::CNT_W-1:0];
            wrcs_pkg::CFG_WEIGHT_TABLE: model_weight_tbl   = data;
            default: ;
        endcase
    endtask

    // Upper data bits beyond a count register carry noise
    task automatic apply_settings(bit [wrcs_pkg::CNT_W-1:0] children,
                                  bit [wrcs_pkg::CNT_W-1:0] weights,
                                  bit [wrcs_pkg::TABLE_W-1:0] weight_tbl);
        bit [wrcs_pkg::TABLE_W-1:0] noise;
        noise = {$urandom, $urandom};
        write_reg(wrcs_pkg::CFG_CHILD_COUNT,
                  {noise[wrcs_pkg::TABLE_W-1:wrcs_pkg::CNT_W], children});
        noise = {$urandom, $urandom};
        write_reg(wrcs_pkg::CFG_WEIGHT_COUNT,
                  {noise[wrcs_pkg::TABLE_W-1:wrcs_pkg::CNT_W], weights});
        write_reg(wrcs_pkg::CFG_WEIGHT_TABLE, weight_tbl);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        settings_applied++;
    endtask

    function automatic bit [wrcs_pkg::TABLE_W-1:0] random_weight_tbl();
        bit [wrcs_pkg::TABLE_W-1:0] tbl;
        int unsigned                style;
        style = $urandom_range(4);
        tbl   = {$urandom, $urandom};
        for (int i = 0; i < wrcs_pkg::MAX_CHILDREN; i++) begin
            case (style)
                0: ;                                                   // anything
                1: tbl[8*i +: 8] = 8'($urandom_range(31));             // small positive
                2: tbl[8*i +: 8] = $urandom_range(1) ? 8'h00 : {1'b1, 7'($urandom)};
                3: tbl[8*i +: 8] = 8'h7F;                              // all at maximum
                default: if ($urandom_range(3) == 0) tbl[8*i +: 8] = 8'h00;
            endcase
        end
        return tbl;
    endfunction

    function automatic t_request random_request();
        t_request req;
        req.first = ($urandom_range(9) != 0);
        case ($urandom_range(9))
            0:       req.mask = '0;
            1:       req.mask = '1;
            2:       req.mask = wrcs_pkg::MAX_CHILDREN'(1)
                                << $urandom_range(wrcs_pkg::MAX_CHILDREN - 1);
            default: req.mask = wrcs_pkg::MAX_CHILDREN'($urandom);
        endcase
        case ($urandom_range(9))
            0:       req.word = '0;
            1:       req.word = '1;
            2, 3:    req.word = wheel_edge_word(req.mask);
            default: req.word = wrcs_pkg::RND_W'($urandom);
        endcase
        return req;
    endfunction

    // Stimulus sequence
    initial begin
        bit [wrcs_pkg::CNT_W-1:0] children;
        bit [wrcs_pkg::CNT_W-1:0] weights;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: no children, everything returns to parent
        queue_request(1'b1, 8'hFF, 16'h0000);
        queue_request(1'b1, 8'hFF, 16'hFFFF);
        wait_drained();

        // mixed weights: maximum, negative, zero and small entries
        apply_settings(4'd8, 4'd8, 64'h7F80_FF00_1001_2040);
        queue_request(1'b0, 8'hFF, 16'h1234);
        queue_request(1'b1, 8'h00, 16'h8000);
        queue_request(1'b1, 8'hFF, 16'h0000);
        queue_request(1'b1, 8'hFF, 16'hFFFF);
        queue_request(1'b1, 8'h01, 16'h8000);
        queue_request(1'b1, 8'h80, 16'hFFFF);
        queue_request(1'b1, 8'h42, 16'h7FFF);
        wait_drained();

        // total weight zero among the allowed children
        apply_settings(4'd5, 4'd8, 64'h0000_0080_FF00_8100);
        queue_request(1'b1, 8'h1F, 16'h0000);
        queue_request(1'b1, 8'h1F, 16'hFFFF);
        queue_request(1'b1, 8'h1F, 16'h3333);
        queue_request(1'b1, 8'h14, 16'h8000);
        wait_drained();

        // child count above the maximum and a large weight count
        apply_settings(4'd15, 4'd15, 64'h0102_0408_1020_4080);
        queue_request(1'b1, 8'hFF, 16'hFFFF);
        queue_request(1'b1, 8'hF0, 16'h4000);
        queue_request(1'b1, 8'h80, 16'h0000);
        wait_drained();

        // no explicit weights; mask bits beyond the children are ignored
        apply_settings(4'd3, 4'd0, 64'h0);
        queue_request(1'b1, 8'hF8, 16'h1111);
        queue_request(1'b1, 8'hFF, 16'h5555);
        queue_request(1'b1, 8'hFF, 16'hAAAB);
        queue_request(1'b1, 8'h05, 16'hFFFF);
        wait_drained();

        // random phases, each under its own settings and sender idling
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            children = ($urandom_range(9) == 0) ? wrcs_pkg::CNT_W'($urandom_range(15))
                                                : wrcs_pkg::CNT_W'($urandom_range(2, 8));
            weights  = wrcs_pkg::CNT_W'($urandom_range(15));
            case (p)
                0: begin children = 4'd8;  weights = 4'd8;  end
                1: children = 4'd1;
                2: begin children = 4'd15; weights = 4'd15; end
                3: weights = 4'd0;
                default: ;
            endcase
            apply_settings(children, weights, random_weight_tbl());
            idle_pct = idle_profile[p % 3];
            for (int n = 0; n < PHASE_REQUESTS; n++)
                pending_requests.push_back(random_request());
            wait_drained();
            idle_pct = 0;
        end

        $display("Ran %0d requests under %0d register settings.", requests_taken,
                 settings_applied);
        $display("%0d picked a child, %0d returned to parent, %0d mismatches.",
                 child_results, parent_results, mismatch_count);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/wrcs_pkg.sv
rtl/core/weighted_random_child_select.sv
test/tb_weighted_random_child_select.sv
